[rtl/lwdd_pkg.sv]
package lwdd_pkg;

    // Table sizes
    localparam int NUM_THREADS = 16;
    localparam int NUM_LOCKS   = 64;

    // Request/response field widths
    localparam int TID_W    = 4;
    localparam int LID_W    = 6;
    localparam int STATUS_W = 3;

    // Internal index widths
    localparam int THR_W  = $clog2(NUM_THREADS);
    localparam int LCK_W  = $clog2(NUM_LOCKS);
    localparam int STEP_W = $clog2(NUM_THREADS + 1);
    localparam int CMP_W  = (THR_W > LCK_W) ? THR_W : LCK_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED         = 3'd0,
        ST_WAITING         = 3'd1,
        ST_DEADLOCK        = 3'd2,
        ST_RELEASED        = 3'd3,
        ST_NOT_OWNER       = 3'd4,
        ST_ALREADY_WAITING = 3'd5
    } t_status;

    // Owner table access
    typedef struct packed {
        logic [LCK_W-1:0] raddr;
        logic             we;
        logic [LCK_W-1:0] waddr;
        logic             wvld;
        logic [THR_W-1:0] wthr;
    } t_own_cmd;

    typedef struct packed {
        logic             vld;
        logic [THR_W-1:0] thr;
    } t_own_ent;

    // Wait table access
    typedef struct packed {
        logic [THR_W-1:0] raddr;
        logic             we;
        logic [THR_W-1:0] waddr;
        logic             wvld;
        logic [LCK_W-1:0] wlock;
    } t_wait_cmd;

    typedef struct packed {
        logic             vld;
        logic [LCK_W-1:0] lock;
    } t_wait_ent;

    typedef struct packed {
        t_status          status;
        logic             nov;
        logic [TID_W-1:0] new_owner;
        logic             dl;
    } t_result;

    typedef struct packed {
        logic done;
        logic dl_seen;
    } t_ctrl_stat;

    // Thread number modulo NUM_THREADS, by restoring subtraction
    function automatic logic [THR_W-1:0] thr_reduce(input logic [TID_W-1:0] v);
        logic [TID_W:0] r;
        r = {1'b0, v};
        for (int k = TID_W - 1; k >= 0; k--) begin
            if (int'(r) >= (NUM_THREADS << k)) begin
                r = r - (TID_W + 1)'(NUM_THREADS << k);
            end
        end
        return THR_W'(r);
    endfunction

    // Lock number modulo NUM_LOCKS
    function automatic logic [LCK_W-1:0] lck_reduce(input logic [LID_W-1:0] v);
        logic [LID_W:0] r;
        r = {1'b0, v};
        for (int k = LID_W - 1; k >= 0; k--) begin
            if (int'(r) >= (NUM_LOCKS << k)) begin
                r = r - (LID_W + 1)'(NUM_LOCKS << k);
            end
        end
        return LCK_W'(r);
    endfunction

endpackage

[rtl/lwdd_ifs.sv]
// Request channel
interface lwdd_req_if;
    import lwdd_pkg::*;

    logic             valid;
    logic             ready;
    logic             mode;
    logic [TID_W-1:0] thread_id;
    logic [LID_W-1:0] lock_id;

    modport source(output valid, mode, thread_id, lock_id, input ready);
    modport sink(input valid, mode, thread_id, lock_id, output ready);
endinterface

// Response channel
interface lwdd_rsp_if;
    import lwdd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                new_owner_valid;
    logic [TID_W-1:0]    new_owner;
    logic                deadlock_latched;

    modport source(output valid, status, new_owner_valid, new_owner, deadlock_latched,
                   input ready);
    modport sink(input valid, status, new_owner_valid, new_owner, deadlock_latched,
                 output ready);
endinterface

[rtl/lwdd_owner_tbl.sv]
module lwdd_owner_tbl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lwdd_pkg::t_own_cmd  i_cmd,
    output lwdd_pkg::t_own_ent  o_rd
);
    import lwdd_pkg::*;

    logic [NUM_LOCKS-1:0] r_vld;
    logic [THR_W-1:0]     r_mem [NUM_LOCKS];
    logic                 r_rd_vld;
    logic [THR_W-1:0]     r_rd_thr;

    // Held flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.we) begin
            r_vld[i_cmd.waddr] <= i_cmd.wvld;
        end
    end

    // Owner thread store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wthr;
        end
        r_rd_thr <= r_mem[i_cmd.raddr];
        r_rd_vld <= r_vld[i_cmd.raddr];
    end

    assign o_rd = '{vld: r_rd_vld, thr: r_rd_thr};

endmodule

[rtl/lwdd_wait_tbl.sv]
module lwdd_wait_tbl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lwdd_pkg::t_wait_cmd i_cmd,
    output lwdd_pkg::t_wait_ent o_rd
);
    import lwdd_pkg::*;

    logic [NUM_THREADS-1:0] r_vld;
    logic [LCK_W-1:0]       r_mem [NUM_THREADS];
    logic                   r_rd_vld;
    logic [LCK_W-1:0]       r_rd_lock;

    // Waiting flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.we) begin
            r_vld[i_cmd.waddr] <= i_cmd.wvld;
        end
    end

    // Waited-lock store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wlock;
        end
        r_rd_lock <= r_mem[i_cmd.raddr];
        r_rd_vld  <= r_vld[i_cmd.raddr];
    end

    assign o_rd = '{vld: r_rd_vld, lock: r_rd_lock};

endmodule

[rtl/lwdd_ctrl.sv]
module lwdd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lwdd_req_if.sink             i_req,
    input  logic                 i_slot_free,
    input  lwdd_pkg::t_own_ent   i_own_rd,
    input  lwdd_pkg::t_wait_ent  i_wait_rd,
    output lwdd_pkg::t_own_cmd   o_own_cmd,
    output lwdd_pkg::t_wait_cmd  o_wait_cmd,
    output lwdd_pkg::t_result    o_res,
    output lwdd_pkg::t_ctrl_stat o_stat
);
    import lwdd_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CHK  = 6'b000010,
        S_HOLD = 6'b000100,
        S_WAIT = 6'b001000,
        S_SCAN = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic              r_mode, n_mode;
    logic [THR_W-1:0]  r_tid, n_tid;
    logic [LCK_W-1:0]  r_lock, n_lock;
    logic [LCK_W-1:0]  r_cur, n_cur;
    logic [THR_W-1:0]  r_idx, n_idx;
    logic [STEP_W-1:0] r_step, n_step;
    t_status           r_status, n_status;
    logic              r_nov, n_nov;
    logic [TID_W-1:0]  r_new, n_new;
    logic              r_dl, n_dl;

    // Shared equality comparator
    logic [CMP_W-1:0]  cmp_a, cmp_b;
    logic              cmp_eq;

    assign cmp_eq = (cmp_a == cmp_b);

    always_comb begin
        cmp_a = CMP_W'(r_tid);
        cmp_b = CMP_W'(i_own_rd.thr);
        case (r_state)
            S_SCAN: begin
                cmp_a = CMP_W'(r_lock);
                cmp_b = CMP_W'(i_wait_rd.lock);
            end
            default: begin
                cmp_a = CMP_W'(r_tid);
                cmp_b = CMP_W'(i_own_rd.thr);
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_tid    = r_tid;
        n_lock   = r_lock;
        n_cur    = r_cur;
        n_idx    = r_idx;
        n_step   = r_step;
        n_status = r_status;
        n_nov    = r_nov;
        n_new    = r_new;
        n_dl     = r_dl;

        o_own_cmd  = '{raddr: r_cur, we: 1'b0, waddr: r_lock, wvld: 1'b0, wthr: r_tid};
        o_wait_cmd = '{raddr: r_tid, we: 1'b0, waddr: r_tid, wvld: 1'b0, wlock: r_lock};

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode = i_req.mode;
                    n_tid  = thr_reduce(i_req.thread_id);
                    n_lock = lck_reduce(i_req.lock_id);
                    n_cur  = n_lock;
                    n_nov  = 1'b0;
                    n_new  = '0;
                    o_own_cmd.raddr  = n_lock;
                    o_wait_cmd.raddr = n_tid;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_mode) begin
                    if (i_wait_rd.vld) begin
                        n_status = ST_ALREADY_WAITING;
                        n_state  = S_DONE;
                    end else if (!i_own_rd.vld) begin
                        o_own_cmd.we   = 1'b1;
                        o_own_cmd.wvld = 1'b1;
                        n_status = ST_GRANTED;
                        n_state  = S_DONE;
                    end else begin
                        // owner entry of the lock is read again for the walk
                        n_step  = '0;
                        n_state = S_HOLD;
                    end
                end else begin
                    if (!i_own_rd.vld || !cmp_eq) begin
                        n_status = ST_NOT_OWNER;
                        n_state  = S_DONE;
                    end else begin
                        n_idx = '0;
                        o_wait_cmd.raddr = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_HOLD: begin
                // owner of the current lock in the chain
                if (!i_own_rd.vld) begin
                    o_wait_cmd.we = 1'b1;
                    o_wait_cmd.wvld = 1'b1;
                    n_status = ST_WAITING;
                    n_state  = S_DONE;
                end else if (cmp_eq) begin
                    n_dl     = 1'b1;
                    n_status = ST_DEADLOCK;
                    n_state  = S_DONE;
                end else begin
                    o_wait_cmd.raddr = i_own_rd.thr;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                // what the holder itself waits on
                if (!i_wait_rd.vld) begin
                    o_wait_cmd.we = 1'b1;
                    o_wait_cmd.wvld = 1'b1;
                    n_status = ST_WAITING;
                    n_state  = S_DONE;
                end else if (r_step == STEP_W'(NUM_THREADS)) begin
                    // cycle that does not pass through the requester
                    n_dl     = 1'b1;
                    n_status = ST_DEADLOCK;
                    n_state  = S_DONE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                    n_cur  = i_wait_rd.lock;
                    o_own_cmd.raddr = i_wait_rd.lock;
                    n_state = S_HOLD;
                end
            end
            S_SCAN: begin
                // lowest-numbered waiter on the released lock takes it
                if (i_wait_rd.vld && cmp_eq) begin
                    o_wait_cmd.we    = 1'b1;
                    o_wait_cmd.waddr = r_idx;
                    o_wait_cmd.wvld  = 1'b0;
                    o_wait_cmd.wlock = '0;
                    o_own_cmd.we   = 1'b1;
                    o_own_cmd.wvld = 1'b1;
                    o_own_cmd.wthr = r_idx;
                    n_nov    = 1'b1;
                    n_new    = TID_W'(r_idx);
                    n_status = ST_RELEASED;
                    n_state  = S_DONE;
                end else if (r_idx == THR_W'(NUM_THREADS - 1)) begin
                    o_own_cmd.we   = 1'b1;
                    o_own_cmd.wvld = 1'b0;
                    o_own_cmd.wthr = '0;
                    n_status = ST_RELEASED;
                    n_state  = S_DONE;
                end else begin
                    n_idx = r_idx + THR_W'(1);
                    o_wait_cmd.raddr = n_idx;
                end
            end
            S_DONE: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dl    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dl    <= n_dl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_tid    <= n_tid;
        r_lock   <= n_lock;
        r_cur    <= n_cur;
        r_idx    <= n_idx;
        r_step   <= n_step;
        r_status <= n_status;
        r_nov    <= n_nov;
        r_new    <= n_new;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res  = '{status: r_status, nov: r_nov, new_owner: r_new, dl: r_dl};
    assign o_stat = '{done: (r_state == S_DONE), dl_seen: r_dl};

endmodule

[rtl/lock_wait_deadlock_detector_core.sv]
// Lock manager with wait-for chain deadlock detection.
// i_req carries one request: mode (0 release, 1 acquire), thread_id and lock_id;
// it is taken when valid and ready are both high. o_rsp returns exactly one
// response per request: status, new_owner_valid/new_owner for a hand-over on
// release, and the sticky deadlock_latched flag.
// Flow, from acceptance to the response appearing on o_rsp:
//   acquire answered from the tables (granted / already waiting): one read of
//   each table; acquire that walks the chain: the owner entry and then the
//   holder's wait entry are read in turn for each lock visited, the walk being
//   serial because of the single read port of each table;
//   release: refused after the owner read, else the waiter entries are scanned
//   in thread order, one waiter entry compared per cycle.
// One request is in work at a time; ready is high only in the idle cycles after
// a response is loaded.
// A finished response sits in an output register, so the next request is
// taken while the receiver stalls; if that one finishes before the previous
// response is taken, the sequencer holds it until the register frees.
// Reset frees all locks, clears all waits and the deadlock flag; the tables
// need no clearing pass.
module lock_wait_deadlock_detector_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lwdd_req_if.sink  i_req,
    lwdd_rsp_if.source o_rsp
);
    import lwdd_pkg::*;

    t_own_cmd   own_cmd;
    t_own_ent   own_rd;
    t_wait_cmd  wait_cmd;
    t_wait_ent  wait_rd;
    t_result    res;
    t_ctrl_stat stat;
    logic       slot_free;

    logic       r_out_vld;
    t_result    r_out;

    // Sequencer and compare unit
    lwdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_slot_free (slot_free),
        .i_own_rd    (own_rd),
        .i_wait_rd   (wait_rd),
        .o_own_cmd   (own_cmd),
        .o_wait_cmd  (wait_cmd),
        .o_res       (res),
        .o_stat      (stat)
    );

    // Per-lock owner table
    lwdd_owner_tbl u_owner_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (own_cmd),
        .o_rd    (own_rd)
    );

    // Per-thread wait table
    lwdd_wait_tbl u_wait_tbl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (wait_cmd),
        .o_rd    (wait_rd)
    );

    // Response register
    assign slot_free = !r_out_vld || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (stat.done && slot_free) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done && slot_free) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid            = r_out_vld;
    assign o_rsp.status           = r_out.status;
    assign o_rsp.new_owner_valid  = r_out.nov;
    assign o_rsp.new_owner        = r_out.new_owner;
    assign o_rsp.deadlock_latched = r_out.dl;

`ifndef NO_ASSERTIONS
    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while previous one still in work");

    // deadlock flag is sticky
    a_dl_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.dl_seen |=> stat.dl_seen)
        else $error("deadlock flag cleared without reset");

    // a deadlock response carries the latched flag
    a_dl_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_DEADLOCK) |-> o_rsp.deadlock_latched)
        else $error("deadlock reported without latched flag");

    // hand-over only on a release
    a_handover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.new_owner_valid) |-> (o_rsp.status == ST_RELEASED))
        else $error("new owner reported on a non-release response");
`endif

endmodule
